>>> sv/stt_pkg.sv
package stt_pkg;

    // Default upper limit on the site index
    localparam int MaxSitesDefault = 4096;

    // Configuration port geometry
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_ABSORB = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CHAIN  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_STIFF  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_POLAR  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_GYRO   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_EFFIC  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_DAMP   = 3'd6;

    // Site status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_ZERO_J  = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    // Depth of the job queue between front and back
    localparam int QueueDepth = 2;

    typedef struct packed {
        logic [12:0]        absorbing_sites;
        logic [12:0]        chain_sites;
        logic [30:0]        stiffness;
        logic signed [31:0] polar;
        logic signed [31:0] gyro;
        logic signed [31:0] effic;
        logic signed [31:0] damp;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] m_x;
        logic signed [15:0] m_y;
        logic signed [15:0] m_z;
        logic signed [16:0] d_x;
        logic signed [16:0] d_y;
        logic signed [16:0] d_z;
        logic [30:0]        coupling;
        logic [1:0]         kind;
    } job_t;

    typedef logic signed [65:0] wide_t;

    // True when v does not fit in signed 32 bits
    function automatic logic sat_hit(input wide_t v);
        return !((&v[65:31]) || (~|v[65:31]));
    endfunction

    // Clamp v to signed 32 bits
    function automatic logic signed [31:0] sat_val(input wide_t v);
        logic signed [31:0] r;
        if (sat_hit(v))
            r = v[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> sv/stt_front.sv
module stt_front #(
    parameter int MAX_SITES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stt_pkg::cfg_t       cfg,
    input  logic                push,
    output logic                full,
    input  logic [12:0]         site_index,
    input  logic signed [15:0]  mag_x,
    input  logic signed [15:0]  mag_y,
    input  logic signed [15:0]  mag_z,
    input  logic [30:0]         exchange_coupling,
    input  logic                pass_start,
    output logic                q_push,
    output stt_pkg::job_t       q_job,
    input  logic                q_full
);
    import stt_pkg::*;

    localparam logic [16:0] SiteLim = 17'(MAX_SITES);

    logic signed [15:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [15:0] base_x, base_y, base_z;
    logic [13:0]        chain_end;
    logic               outside;
    logic               accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;

    // Take the previous vector as zero at the start of a pass
    assign base_x = pass_start ? 16'sd0 : prev_x_reg;
    assign base_y = pass_start ? 16'sd0 : prev_y_reg;
    assign base_z = pass_start ? 16'sd0 : prev_z_reg;

    // Classify the site
    assign chain_end = {1'b0, cfg.absorbing_sites} + {1'b0, cfg.chain_sites};
    assign outside   = (site_index <= cfg.absorbing_sites)
                    || ({1'b0, site_index} > chain_end)
                    || ({4'b0, site_index} > SiteLim);

    always_comb
    begin
        q_job.m_x      = mag_x;
        q_job.m_y      = mag_y;
        q_job.m_z      = mag_z;
        q_job.d_x      = 17'(mag_x) - 17'(base_x);
        q_job.d_y      = 17'(mag_y) - 17'(base_y);
        q_job.d_z      = 17'(mag_z) - 17'(base_z);
        q_job.coupling = exchange_coupling;
        if (outside)
            q_job.kind = ST_OUTSIDE;
        else if (exchange_coupling == 31'd0)
            q_job.kind = ST_ZERO_J;
        else
            q_job.kind = ST_OK;
    end

    // Hold this word's vector for the next site
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
        end
        else if (accept)
        begin
            prev_x_reg <= mag_x;
            prev_y_reg <= mag_y;
            prev_z_reg <= mag_z;
        end
    end

endmodule

>>> sv/stt_queue.sv
module stt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  stt_pkg::job_t wr_job,
    output logic          full,
    output logic          rd_valid,
    output stt_pkg::job_t rd_job,
    input  logic          rd_en
);
    import stt_pkg::*;

    localparam int Depth = QueueDepth;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [PtrW:0]   FullCnt = (PtrW + 1)'(Depth);

    job_t            slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   count_reg;
    logic            do_wr, do_rd;

    assign full     = (count_reg == FullCnt);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> sv/stt_back.sv
module stt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  stt_pkg::job_t      q_job,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic signed [31:0] torque_x,
    output logic signed [31:0] torque_y,
    output logic signed [31:0] torque_z,
    output logic [1:0]         site_status
);
    import stt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_AJ     = 3'd1;
    localparam logic [2:0] S_SQLOAD = 3'd2;
    localparam logic [2:0] S_SQRT   = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [4:0] LastStep = 5'd24;
    localparam logic [4:0] LastIter = 5'd31;

    logic [2:0]         state_reg, state_next;
    job_t               job_reg;
    wide_t              prod_reg;
    wide_t              acc_reg;
    logic [4:0]         step_reg;
    logic [4:0]         cons_step_reg;
    logic               cons_valid_reg;
    logic [63:0]        sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [4:0]         sq_cnt_reg;
    logic [30:0]        r_reg;
    logic signed [31:0] j_reg [3];
    logic signed [31:0] s_reg [3];
    logic signed [31:0] c_reg [3];
    logic signed [31:0] n_reg [3];
    logic signed [31:0] t_reg [3];
    logic signed [31:0] k_reg;
    logic               flag_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic [1:0]         out_st_reg;

    logic signed [32:0] op_a, op_b;
    wide_t              mul;
    logic [63:0]        sq_sum, sq_v_next, sq_res_next;
    logic               sq_ge;
    wide_t              sh15, sh16, cross_v, tsum;
    logic               slot_free;

    function automatic logic signed [32:0] ext16(input logic signed [15:0] v);
        return {{17{v[15]}}, v};
    endfunction

    function automatic logic signed [32:0] ext32(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [32:0] neg17(input logic signed [16:0] v);
        logic signed [17:0] w;
        w = -{v[16], v};
        return {{15{w[17]}}, w};
    endfunction

    assign empty       = !out_valid_reg;
    assign torque_x    = out_x_reg;
    assign torque_y    = out_y_reg;
    assign torque_z    = out_z_reg;
    assign site_status = out_st_reg;
    assign slot_free   = !out_valid_reg || pop;
    assign q_pop       = (state_reg == S_IDLE) && q_valid;

    // Select multiplier operands for the current step
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (state_reg == S_AJ)
        begin
            op_a = {2'b0, cfg.stiffness};
            op_b = {2'b0, job_reg.coupling};
        end
        else
        begin
            case (step_reg)
                5'd0:  begin op_a = neg17(job_reg.d_x); op_b = {2'b0, r_reg}; end
                5'd1:  begin op_a = neg17(job_reg.d_y); op_b = {2'b0, r_reg}; end
                5'd2:  begin op_a = neg17(job_reg.d_z); op_b = {2'b0, r_reg}; end
                5'd3:  begin op_a = ext32(cfg.polar); op_b = ext32(j_reg[0]); end
                5'd4:  begin op_a = ext32(cfg.polar); op_b = ext32(j_reg[1]); end
                5'd5:  begin op_a = ext32(cfg.polar); op_b = ext32(j_reg[2]); end
                5'd6:  begin op_a = ext16(job_reg.m_x); op_b = ext32(s_reg[1]); end
                5'd7:  begin op_a = ext16(job_reg.m_y); op_b = ext32(s_reg[0]); end
                5'd8:  begin op_a = ext16(job_reg.m_z); op_b = ext32(s_reg[0]); end
                5'd9:  begin op_a = ext16(job_reg.m_x); op_b = ext32(s_reg[2]); end
                5'd10: begin op_a = ext16(job_reg.m_y); op_b = ext32(s_reg[2]); end
                5'd11: begin op_a = ext16(job_reg.m_z); op_b = ext32(s_reg[1]); end
                5'd12: begin op_a = ext32(cfg.effic); op_b = ext32(cfg.damp); end
                5'd13: begin op_a = ext16(job_reg.m_x); op_b = ext32(c_reg[1]); end
                5'd14: begin op_a = ext16(job_reg.m_y); op_b = ext32(c_reg[0]); end
                5'd15: begin op_a = ext16(job_reg.m_z); op_b = ext32(c_reg[0]); end
                5'd16: begin op_a = ext16(job_reg.m_x); op_b = ext32(c_reg[2]); end
                5'd17: begin op_a = ext16(job_reg.m_y); op_b = ext32(c_reg[2]); end
                5'd18: begin op_a = ext16(job_reg.m_z); op_b = ext32(c_reg[1]); end
                5'd19: begin op_a = ext32(cfg.gyro); op_b = ext32(c_reg[2]); end
                5'd20: begin op_a = ext32(k_reg);    op_b = ext32(n_reg[2]); end
                5'd21: begin op_a = ext32(cfg.gyro); op_b = ext32(c_reg[1]); end
                5'd22: begin op_a = ext32(k_reg);    op_b = ext32(n_reg[1]); end
                5'd23: begin op_a = ext32(cfg.gyro); op_b = ext32(c_reg[0]); end
                5'd24: begin op_a = ext32(k_reg);    op_b = ext32(n_reg[0]); end
                default: ;
            endcase
        end
    end

    assign mul = op_a * op_b;

    // One square root step
    assign sq_sum      = sq_res_reg + sq_bit_reg;
    assign sq_ge       = sq_v_reg >= sq_sum;
    assign sq_v_next   = sq_ge ? sq_v_reg - sq_sum : sq_v_reg;
    assign sq_res_next = sq_ge ? (sq_res_reg >> 1) + sq_bit_reg : sq_res_reg >> 1;

    // Scale the registered product
    assign sh15    = prod_reg >>> 15;
    assign sh16    = prod_reg >>> 16;
    assign cross_v = (acc_reg - prod_reg) >>> 14;
    assign tsum    = acc_reg + sh16;

    // Sequence one job
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (q_valid)
                    state_next = (q_job.kind == ST_OK) ? S_AJ : S_DONE;
            S_AJ:     state_next = S_SQLOAD;
            S_SQLOAD: state_next = S_SQRT;
            S_SQRT:
                if (sq_cnt_reg == LastIter)
                    state_next = S_MUL;
            S_MUL:
                if (cons_valid_reg && cons_step_reg == LastStep)
                    state_next = S_DONE;
            S_DONE:
                if (slot_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cons_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_MUL)
                cons_valid_reg <= (step_reg <= LastStep);
            else
                cons_valid_reg <= 1'b0;
            if (state_reg == S_DONE && slot_free)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg  <= q_job;
                flag_reg <= 1'b0;
                step_reg <= '0;
                for (int i = 0; i < 3; i++)
                    t_reg[i] <= '0;
            end
            S_AJ:
                prod_reg <= mul;
            S_SQLOAD:
            begin
                sq_v_reg   <= prod_reg[63:0];
                sq_res_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
                sq_cnt_reg <= '0;
            end
            S_SQRT:
            begin
                sq_v_reg   <= sq_v_next;
                sq_res_reg <= sq_res_next;
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                r_reg      <= sq_res_next[30:0];
            end
            S_MUL:
            begin
                if (step_reg <= LastStep)
                begin
                    prod_reg      <= mul;
                    cons_step_reg <= step_reg;
                    step_reg      <= step_reg + 1'b1;
                end
                if (cons_valid_reg)
                begin
                    case (cons_step_reg)
                        5'd0, 5'd1, 5'd2:
                        begin
                            j_reg[cons_step_reg[1:0]] <= sat_val(sh15);
                            flag_reg <= flag_reg | sat_hit(sh15);
                        end
                        5'd3:  begin s_reg[0] <= sat_val(sh16); flag_reg <= flag_reg | sat_hit(sh16); end
                        5'd4:  begin s_reg[1] <= sat_val(sh16); flag_reg <= flag_reg | sat_hit(sh16); end
                        5'd5:  begin s_reg[2] <= sat_val(sh16); flag_reg <= flag_reg | sat_hit(sh16); end
                        5'd12: begin k_reg    <= sat_val(sh16); flag_reg <= flag_reg | sat_hit(sh16); end
                        5'd6, 5'd8, 5'd10, 5'd13, 5'd15, 5'd17:
                            acc_reg <= prod_reg;
                        5'd7:  begin c_reg[2] <= sat_val(cross_v); flag_reg <= flag_reg | sat_hit(cross_v); end
                        5'd9:  begin c_reg[1] <= sat_val(cross_v); flag_reg <= flag_reg | sat_hit(cross_v); end
                        5'd11: begin c_reg[0] <= sat_val(cross_v); flag_reg <= flag_reg | sat_hit(cross_v); end
                        5'd14: begin n_reg[2] <= sat_val(cross_v); flag_reg <= flag_reg | sat_hit(cross_v); end
                        5'd16: begin n_reg[1] <= sat_val(cross_v); flag_reg <= flag_reg | sat_hit(cross_v); end
                        5'd18: begin n_reg[0] <= sat_val(cross_v); flag_reg <= flag_reg | sat_hit(cross_v); end
                        5'd19, 5'd21, 5'd23:
                            acc_reg <= sh16;
                        5'd20: begin t_reg[2] <= sat_val(tsum); flag_reg <= flag_reg | sat_hit(tsum); end
                        5'd22: begin t_reg[1] <= sat_val(tsum); flag_reg <= flag_reg | sat_hit(tsum); end
                        5'd24: begin t_reg[0] <= sat_val(tsum); flag_reg <= flag_reg | sat_hit(tsum); end
                        default: ;
                    endcase
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_x_reg <= t_reg[0];
                    out_y_reg <= t_reg[1];
                    out_z_reg <= t_reg[2];
                    if (job_reg.kind != ST_OK)
                        out_st_reg <= job_reg.kind;
                    else
                        out_st_reg <= flag_reg ? ST_SAT : ST_OK;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> sv/spin_transfer_torque_site_unit.sv
// Spin-transfer torque for one site of a 1-D chain.
// Input channel: push/full. One word carries a site's index, its
// magnetization (Q2.14) and exchange coupling J (Q16.16); pass_start
// clears the kept previous-site vector first. Result channel: empty/pop.
// One word per input word: torque x/y/z in saturated Q16.16 and a status.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle; the block does not enforce this.
// A front stage classifies each site and forms m - m_prev, a two-word
// queue decouples it from the back stage, which runs one shared 33x33
// multiplier and a 32-step bit-serial square root.
// A site in the chain passes through one product, 32 root steps, 25 products
// and a drain; a site outside the chain or with zero coupling skips them.
// The back stage takes a new site only once it is done with the last one, so
// the shared multiplier and the root loop bound the rate for in-chain sites.
// Reset clears the configuration registers to zero, the previous vector to
// zero and the job queue and result word to empty. When the receiver stalls,
// the finished word holds on the result ports; the back stage waits and the
// front queue fills, after which full rises.
module spin_transfer_torque_site_unit #(
    parameter int MAX_SITES = stt_pkg::MaxSitesDefault
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [stt_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [stt_pkg::CfgDataW-1:0] cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [12:0]                  site_index,
    input  logic signed [15:0]           mag_x,
    input  logic signed [15:0]           mag_y,
    input  logic signed [15:0]           mag_z,
    input  logic [30:0]                  exchange_coupling,
    input  logic                         pass_start,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [31:0]           torque_x,
    output logic signed [31:0]           torque_y,
    output logic signed [31:0]           torque_z,
    output logic [1:0]                   site_status
);
    import stt_pkg::*;

    cfg_t cfg_reg;
    logic q_push, q_full, q_valid, q_pop;
    job_t wr_job, rd_job;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ABSORB: cfg_reg.absorbing_sites <= cfg_data[12:0];
                REG_CHAIN:  cfg_reg.chain_sites     <= cfg_data[12:0];
                REG_STIFF:  cfg_reg.stiffness       <= cfg_data[30:0];
                REG_POLAR:  cfg_reg.polar           <= cfg_data;
                REG_GYRO:   cfg_reg.gyro            <= cfg_data;
                REG_EFFIC:  cfg_reg.effic           <= cfg_data;
                REG_DAMP:   cfg_reg.damp            <= cfg_data;
                default: ;
            endcase
        end
    end

    stt_front #(.MAX_SITES(MAX_SITES)) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .push              (push),
        .full              (full),
        .site_index        (site_index),
        .mag_x             (mag_x),
        .mag_y             (mag_y),
        .mag_z             (mag_z),
        .exchange_coupling (exchange_coupling),
        .pass_start        (pass_start),
        .q_push            (q_push),
        .q_job             (wr_job),
        .q_full            (q_full)
    );

    stt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_job   (wr_job),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_job   (rd_job),
        .rd_en    (q_pop)
    );

    stt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_job       (rd_job),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .torque_x    (torque_x),
        .torque_y    (torque_y),
        .torque_z    (torque_z),
        .site_status (site_status)
    );

endmodule

>>> sv/stt_checker.sv
module stt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [31:0] torque_x,
    input logic signed [31:0] torque_y,
    input logic signed [31:0] torque_z,
    input logic [1:0]         site_status
);
    import stt_pkg::*;

    // Under reset no result is offered and the input is not full
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queues not empty under reset");

    // Skipped sites carry a zero torque
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (site_status == ST_OUTSIDE || site_status == ST_ZERO_J))
        |-> (torque_x == 32'sd0 && torque_y == 32'sd0 && torque_z == 32'sd0))
        else $error("nonzero torque on skipped site");

    // A stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(torque_x) && $stable(torque_y)
                              && $stable(torque_z) && $stable(site_status)))
        else $error("result changed while stalled");

endmodule

bind spin_transfer_torque_site_unit stt_checker u_chk (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import stt_pkg::*;

    localparam int HalfPeriod   = 2;
    localparam int MaxSites     = MaxSitesDefault;
    localparam int DrainCycles  = 200;
    localparam int StallLimit   = 20000;
    localparam int RandomItems  = 1800;

    typedef struct {
        logic [12:0]        site;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
        logic [30:0]        coupling;
        logic               start;
    } site_word_t;

    typedef struct {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic [1:0]         status;
    } torque_word_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic                push = 1'b0;
    logic                full;
    logic [12:0]         site_index = '0;
    logic signed [15:0]  mag_x = '0;
    logic signed [15:0]  mag_y = '0;
    logic signed [15:0]  mag_z = '0;
    logic [30:0]         exchange_coupling = '0;
    logic                pass_start = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic signed [31:0]  torque_x;
    logic signed [31:0]  torque_y;
    logic signed [31:0]  torque_z;
    logic [1:0]          site_status;

    // Model copy of the registers and kept vector
    logic [12:0]        m_absorb;
    logic [12:0]        m_chain;
    logic [30:0]        m_stiff;
    logic signed [31:0] m_polar;
    logic signed [31:0] m_gyro;
    logic signed [31:0] m_effic;
    logic signed [31:0] m_damp;
    logic signed [15:0] last_mag [3];

    site_word_t   pending_sites[$];
    torque_word_t expected_torques[$];

    int  errors = 0;
    int  checked = 0;
    int  saturated_seen = 0;
    int  outside_seen = 0;
    int  zero_j_seen = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_results = 1'b0;
    int  send_gap = 0;
    int  take_gap = 0;

    spin_transfer_torque_site_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .site_index(site_index), .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
        .exchange_coupling(exchange_coupling), .pass_start(pass_start),
        .empty(empty), .pop(pop),
        .torque_x(torque_x), .torque_y(torque_y), .torque_z(torque_z),
        .site_status(site_status)
    );

    always #HalfPeriod clk = ~clk;

    // Floor shift of a wide signed value
    function automatic logic signed [127:0] floor_shift(input logic signed [127:0] v,
                                                        input int sh);
        return v >>> sh;
    endfunction

    // Clamp to signed 32 bits, flag on overflow
    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                   inout bit hit);
        if (v > 128'sd2147483647)
        begin
            hit = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (v < -128'sd2147483648)
        begin
            hit = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Cross product of a Q2.14 vector and a Q16.16 vector
    function automatic void cross_q(input logic signed [127:0] u [3],
                                    input logic signed [127:0] v [3],
                                    output logic signed [127:0] o [3], inout bit hit);
        o[0] = clamp32(floor_shift(u[1] * v[2] - u[2] * v[1], 14), hit);
        o[1] = clamp32(floor_shift(u[2] * v[0] - u[0] * v[2], 14), hit);
        o[2] = clamp32(floor_shift(u[0] * v[1] - u[1] * v[0], 14), hit);
    endfunction

    // Work out the torque word of one site and advance the kept vector
    function automatic torque_word_t site_torque(input site_word_t w);
        torque_word_t r;
        logic signed [127:0] m [3];
        logic signed [127:0] s [3];
        logic signed [127:0] c [3];
        logic signed [127:0] n [3];
        logic signed [127:0] t [3];
        logic signed [127:0] rt;
        logic signed [127:0] dd;
        logic signed [127:0] jj;
        logic signed [127:0] k;
        logic [13:0] upper;
        bit hit;
        hit = 1'b0;
        m[0] = w.mx;
        m[1] = w.my;
        m[2] = w.mz;
        if (w.start)
            foreach (last_mag[i]) last_mag[i] = '0;
        foreach (t[i]) t[i] = 0;
        upper = {1'b0, m_absorb} + {1'b0, m_chain};
        if (w.site <= m_absorb || {1'b0, w.site} > upper || w.site > MaxSites)
            r.status = ST_OUTSIDE;
        else if (w.coupling == 0)
            r.status = ST_ZERO_J;
        else
        begin
            rt = $signed({64'd0, root64(64'(m_stiff) * 64'(w.coupling))});
            for (int i = 0; i < 3; i++)
            begin
                dd = m[i] - 128'(last_mag[i]);
                jj = clamp32(floor_shift(-(dd * rt), 15), hit);
                s[i] = clamp32(floor_shift(128'(m_polar) * jj, 16), hit);
            end
            cross_q(m, s, c, hit);
            cross_q(m, c, n, hit);
            k = clamp32(floor_shift(128'(m_effic) * 128'(m_damp), 16), hit);
            for (int i = 0; i < 3; i++)
                t[i] = clamp32(floor_shift(128'(m_gyro) * c[i], 16)
                               + floor_shift(k * n[i], 16), hit);
            r.status = hit ? ST_SAT : ST_OK;
        end
        last_mag[0] = w.mx;
        last_mag[1] = w.my;
        last_mag[2] = w.mz;
        r.tx = t[0][31:0];
        r.ty = t[1][31:0];
        r.tz = t[2][31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    // Write one register and the model copy
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_ABSORB: m_absorb = val[12:0];
            REG_CHAIN:  m_chain = val[12:0];
            REG_STIFF:  m_stiff = val[30:0];
            REG_POLAR:  m_polar = val;
            REG_GYRO:   m_gyro = val;
            REG_EFFIC:  m_effic = val;
            default:    m_damp = val;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] ab, input logic [31:0] ch,
                             input logic [31:0] st, input logic [31:0] po,
                             input logic [31:0] gy, input logic [31:0] ef,
                             input logic [31:0] dm);
        write_reg(REG_ABSORB, ab);
        write_reg(REG_CHAIN, ch);
        write_reg(REG_STIFF, st);
        write_reg(REG_POLAR, po);
        write_reg(REG_GYRO, gy);
        write_reg(REG_EFFIC, ef);
        write_reg(REG_DAMP, dm);
    endtask

    // Wait until the block has nothing left, then let it settle
    task automatic drain_all();
        wait (pending_sites.size() == 0 && !push && expected_torques.size() == 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_mag();
        case ($urandom_range(0, 5))
            0: return 16'sh4000;
            1: return -16'sh4000;
            2: return 16'($urandom);
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic logic [30:0] rand_coupling();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 31'h7fff_ffff;
            2: return 31'($urandom);
            default: return 31'($urandom_range(1, 32'h0008_0000));
        endcase
    endfunction

    task automatic queue_site(input logic [12:0] site, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic signed [15:0] z,
                              input logic [30:0] j, input logic st);
        site_word_t w;
        w.site = site;
        w.mx = x;
        w.my = y;
        w.mz = z;
        w.coupling = j;
        w.start = st;
        pending_sites.push_back(w);
    endtask

    // Queue one chain pass: mostly in order, with some noise
    task automatic queue_pass(input int len);
        logic [12:0] s;
        s = m_absorb + 13'd1;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                s = 13'($urandom);
            queue_site(s, rand_mag(), rand_mag(), rand_mag(), rand_coupling(), i == 0);
            s = s + 13'd1;
        end
    endtask

    // Driver: feed sites from the pending queue
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            expected_torques.push_back(site_torque(pending_sites.pop_front()));
        end
        if (push && full)
            ;
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            push <= 1'b0;
        end
        else if ((pending_sites.size() > 0) && rst_n)
        begin
            site_word_t w;
            w = pending_sites[0];
            push <= 1'b1;
            site_index <= w.site;
            mag_x <= w.mx;
            mag_y <= w.my;
            mag_z <= w.mz;
            exchange_coupling <= w.coupling;
            pass_start <= w.start;
            if (!calm && $urandom_range(0, 7) == 0)
                send_gap <= $urandom_range(1, 6);
        end
        else
            push <= 1'b0;
    end

    // Monitor: take torque words and compare
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (expected_torques.size() == 0)
                report_mismatch("unexpected word", torque_x, 32'd0);
            else
            begin
                torque_word_t e;
                e = expected_torques.pop_front();
                checked++;
                if (site_status == ST_SAT) saturated_seen++;
                if (site_status == ST_OUTSIDE) outside_seen++;
                if (site_status == ST_ZERO_J) zero_j_seen++;
                if (torque_x !== e.tx) report_mismatch("torque_x", torque_x, e.tx);
                if (torque_y !== e.ty) report_mismatch("torque_y", torque_y, e.ty);
                if (torque_z !== e.tz) report_mismatch("torque_z", torque_z, e.tz);
                if (site_status !== e.status)
                    report_mismatch("site_status", 32'(site_status), 32'(e.status));
            end
        end
        if (hold_results)
            pop <= 1'b0;
        else if (take_gap > 0)
        begin
            take_gap <= take_gap - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
                take_gap <= $urandom_range(1, 6);
        end
    end

    // Watchdog on progress
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("[spin_transfer_torque_site_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        m_absorb = '0;
        m_chain = '0;
        m_stiff = '0;
        m_polar = '0;
        m_gyro = '0;
        m_effic = '0;
        m_damp = '0;
        foreach (last_mag[i]) last_mag[i] = '0;
        #1;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers give every site outside the chain
        queue_site(13'd1, 16'sh4000, -16'sh4000, 16'sh0, 31'd65536, 1'b0);
        drain_all();

        write_all(32'd2, 32'd6, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                  32'h0000_8000, 32'h0001_0000);
        queue_site(13'd0, 16'sh1000, 16'sh0, 16'sh0, 31'd65536, 1'b1);
        queue_site(13'd2, 16'sh4000, 16'sh0, 16'sh0, 31'd65536, 1'b0);
        queue_site(13'd3, 16'sh4000, 16'sh2000, -16'sh4000, 31'd65536, 1'b1);
        queue_site(13'd4, -16'sh4000, 16'sh4000, 16'sh4000, 31'h7fff_ffff, 1'b0);
        queue_site(13'd5, 16'sh0, -16'sh4000, 16'sh1234, 31'd0, 1'b0);
        queue_site(13'd6, 16'sh7fff, 16'sh8000, 16'sh5555, 31'd1, 1'b0);
        queue_site(13'd8, 16'shffff, 16'sh0001, 16'sh8000, 31'd300000, 1'b0);
        queue_site(13'd9, 16'sh4000, 16'sh4000, 16'sh4000, 31'd65536, 1'b0);
        queue_site(13'h1fff, 16'sh4000, 16'sh4000, 16'sh4000, 31'd65536, 1'b0);
        drain_all();

        // Zero stiffness, then saturating extremes
        write_all(32'd0, 32'd4096, 32'd0, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000);
        queue_site(13'd1, 16'sh4000, -16'sh4000, 16'sh2000, 31'd65536, 1'b1);
        queue_site(13'd4096, 16'sh4000, 16'sh4000, 16'sh4000, 31'd65536, 1'b0);
        drain_all();
        write_reg(REG_STIFF, 32'h7fff_ffff);
        queue_site(13'd2, -16'sh4000, 16'sh4000, -16'sh2000, 31'h7fff_ffff, 1'b0);
        queue_site(13'd3, 16'sh4000, -16'sh4000, 16'sh4000, 31'd1, 1'b0);
        queue_site(13'd4097, 16'sh4000, 16'sh0, 16'sh0, 31'd1, 1'b0);
        drain_all();

        // Full-range corner: absorbing and chain at max width
        write_all(32'h1fff, 32'h1fff, 32'h0000_4000, 32'hffff_0000, 32'h0002_0000,
                  32'hffff_8000, 32'h0000_4000);
        queue_site(13'h1fff, 16'sh4000, 16'sh0, 16'sh0, 31'd65536, 1'b1);
        queue_site(13'd1, 16'sh4000, 16'sh0, 16'sh0, 31'd65536, 1'b0);
        drain_all();

        // Back pressure: hold results until the input stalls
        write_all(32'd0, 32'd4096, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
                  32'h0001_0000, 32'h0000_2000);
        hold_results = 1'b1;
        queue_pass(12);
        wait (push && full);
        repeat (300) @(posedge clk);
        hold_results = 1'b0;
        drain_all();

        // Random phases with several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_all($urandom_range(0, 40), $urandom_range(0, 120),
                      (ph == 0) ? 32'h7fff_ffff : $urandom_range(0, 32'h0004_0000),
                      $urandom, $urandom, $urandom,
                      (ph == 1) ? 32'h8000_0000 : $urandom);
            if (ph == 5)
                calm = 1'b1;
            for (int n = 0; n < RandomItems / 6; n += 30)
                queue_pass($urandom_range(10, 50));
            drain_all();
        end

        $display("checked %0d torque words: %0d saturated, %0d outside, %0d zero coupling",
                 checked, saturated_seen, outside_seen, zero_j_seen);
        if (errors == 0 && expected_torques.size() == 0)
            $display("[spin_transfer_torque_site_unit] OK");
        else
            $display("[spin_transfer_torque_site_unit] ERROR");
        $finish;
    end

endmodule

>>> spin_transfer_torque_site_unit.f
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/stt_back.sv
sv/spin_transfer_torque_site_unit.sv
sv/stt_checker.sv
tb/testbench.sv
